FILE: hdl/wwkc_pkg.sv
// ----------------------------------------------------------------------------
// wwkc_pkg: shared definitions for the whole-word keyword counter
// Widths, register indexes, byte classifiers and the step record that the
// cell chain hands to the token controller.
// ----------------------------------------------------------------------------
package wwkc_pkg;

   localparam int MAX_KEY_LEN_DEF = 16;
   localparam int BYTE_W          = 8;
   localparam int COUNT_W         = 32;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 2;
   localparam int KEY_LEN_W       = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_CHARS_LOW  = 2'd0,
      CSR_KEY_CHARS_HIGH = 2'd1,
      CSR_KEY_LENGTH     = 2'd2
   } csr_index_type;

   // One accepted request as seen by the token controller.
   typedef struct packed {
      logic accept;
      logic space;
      logic letter;
      logic hit_all;
      logic letter_at_len;
      logic last;
   } step_type;

   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic is_letter(input logic [BYTE_W-1:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'h20) : b;
   endfunction

endpackage

FILE: hdl/wwkc_req_if.sv
// ----------------------------------------------------------------------------
// wwkc_req_if: text request channel
// Valid/ready channel carrying one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface wwkc_req_if;
   logic                       valid;
   logic                       ready;
   logic [wwkc_pkg::BYTE_W-1:0] text_byte;
   logic                       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: hdl/wwkc_rsp_if.sv
// ----------------------------------------------------------------------------
// wwkc_rsp_if: count response channel
// Valid/ready channel carrying the token count of one finished text.
// ----------------------------------------------------------------------------
interface wwkc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [wwkc_pkg::COUNT_W-1:0] match_count;

   modport source (output valid, output match_count, input ready);
   modport sink   (input valid, input match_count, output ready);
endinterface

FILE: hdl/wwkc_cell.sv
// ----------------------------------------------------------------------------
// wwkc_cell: one byte cell of the window chain
// Holds one folded token byte, passes it on to the next cell on each shift
// and compares the byte it is about to take with its keyword byte.
// ----------------------------------------------------------------------------
module wwkc_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [wwkc_pkg::BYTE_W-1:0] byte_in,
   input  logic [wwkc_pkg::BYTE_W-1:0] key_byte,
   input  logic                        cmp_en,
   output logic [wwkc_pkg::BYTE_W-1:0] byte_out,
   output logic                        hit,
   output logic                        letter
);

   logic [wwkc_pkg::BYTE_W-1:0] byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;
   // cells past the key length do not take part
   assign hit      = !cmp_en || (byte_in == key_byte);
   assign letter   = wwkc_pkg::is_letter(byte_in);

endmodule

FILE: hdl/wwkc_token_ctrl.sv
// ----------------------------------------------------------------------------
// wwkc_token_ctrl: token state and running count
// Tracks position in the current token, whether its first keyword
// occurrence is judged or waits for the following byte, and the count.
// ----------------------------------------------------------------------------
module wwkc_token_ctrl #(
   parameter int MaxKeyLen = wwkc_pkg::MAX_KEY_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  wwkc_pkg::step_type             step,
   input  logic [$clog2(MaxKeyLen+1)-1:0] key_len,
   output logic [wwkc_pkg::COUNT_W-1:0]   count_out
);

   localparam int Window = MaxKeyLen + 1;
   localparam int TpW    = $clog2(Window + 1);

   logic [TpW-1:0]               tp_ff, tp_in, tp_step, len_ext;
   logic                         decided_ff, decided_in;
   logic                         awaiting_ff, awaiting_in;
   logic [wwkc_pkg::COUNT_W-1:0] count_ff, count_in, count_sum;
   logic                         bump;

   assign len_ext = TpW'(key_len);
   assign tp_step = (tp_ff == TpW'(Window)) ? tp_ff : tp_ff + 1'b1;

   always_comb begin
      tp_in       = tp_ff;
      decided_in  = decided_ff;
      awaiting_in = awaiting_ff;
      bump        = 1'b0;
      if (step.accept) begin
         if (step.space) begin
            bump        = awaiting_ff;
            tp_in       = '0;
            decided_in  = 1'b0;
            awaiting_in = 1'b0;
         end else begin
            tp_in = tp_step;
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               decided_in  = 1'b1;
               bump        = !step.letter;
            end else if (!decided_ff && (key_len != '0) && (tp_step >= len_ext)
                         && step.hit_all) begin
               // a letter just before the occurrence rules it out
               if ((tp_step > len_ext) && step.letter_at_len) begin
                  decided_in = 1'b1;
               end else begin
                  awaiting_in = 1'b1;
               end
            end
         end
         if (step.last) begin
            // the text end closes an occurrence that waits for its next byte
            bump        = bump || awaiting_in;
            tp_in       = '0;
            decided_in  = 1'b0;
            awaiting_in = 1'b0;
         end
      end
   end

   always_comb begin
      count_sum = count_ff;
      if (bump && (count_ff != '1)) begin
         count_sum = count_ff + 1'b1;
      end
      count_in = (step.accept && step.last) ? '0 : count_sum;
   end

   assign count_out = count_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff       <= '0;
         decided_ff  <= 1'b0;
         awaiting_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         tp_ff       <= tp_in;
         decided_ff  <= decided_in;
         awaiting_ff <= awaiting_in;
         count_ff    <= count_in;
      end
   end

endmodule

FILE: hdl/whole_word_keyword_counter.sv
// ----------------------------------------------------------------------------
// whole_word_keyword_counter: counts tokens holding the keyword as a word
// Folds text to lower case, keeps the newest token bytes in a chain of
// cells with a parallel keyword compare, and emits the count at text end.
//
//   channel   kind        payload                      direction
//   req_bus   valid/ready text_byte, end_of_text       in
//   rsp_bus   valid/ready match_count                  out
//   csr_*     write only  key chars low/high, length   in
//
// One request per cycle unless a held count stalls it; the count appears in
// the cycle after the request marked end_of_text, set by the single output
// register. Requests are taken while it is empty or being drained. Synchronous
// reset clears token state, count, output valid, key chars; key length is 1.
// ----------------------------------------------------------------------------
module whole_word_keyword_counter #(
   parameter int MaxKeyLen = wwkc_pkg::MAX_KEY_LEN_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   wwkc_req_if.sink                         req_bus,
   wwkc_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [wwkc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [wwkc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int Window = MaxKeyLen + 1;
   localparam int LenW   = $clog2(MaxKeyLen + 1);
   localparam int KeyIW  = (MaxKeyLen > 1) ? $clog2(MaxKeyLen) : 1;
   localparam int BW     = wwkc_pkg::BYTE_W;

   logic [wwkc_pkg::CSR_DATA_W-1:0] key_low_ff, key_high_ff;
   logic [wwkc_pkg::KEY_LEN_W-1:0]  key_length_ff;
   logic [LenW-1:0]                 key_len;

   logic [BW-1:0]      key_vec   [MaxKeyLen];
   logic [BW-1:0]      chain_in  [Window];
   logic [BW-1:0]      chain_out [Window];
   logic [BW-1:0]      cell_key  [Window];
   logic [Window-1:0]  cell_cmp, cell_hit, cell_letter;

   logic [BW-1:0]      text_fold;
   logic               accept, text_space;
   wwkc_pkg::step_type step;

   logic [wwkc_pkg::COUNT_W-1:0] count_out;
   logic                         rsp_valid_ff;
   logic [wwkc_pkg::COUNT_W-1:0] rsp_count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= wwkc_pkg::KEY_LEN_W'(1);
      end else if (csr_wr_en) begin
         case (wwkc_pkg::csr_index_type'(csr_index))
            wwkc_pkg::CSR_KEY_CHARS_LOW:  key_low_ff    <= csr_wdata;
            wwkc_pkg::CSR_KEY_CHARS_HIGH: key_high_ff   <= csr_wdata;
            wwkc_pkg::CSR_KEY_LENGTH:     key_length_ff <= csr_wdata[wwkc_pkg::KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign key_len = (int'(key_length_ff) > MaxKeyLen) ? LenW'(MaxKeyLen)
                                                      : LenW'(key_length_ff);

   for (genvar j = 0; j < MaxKeyLen; j++) begin : g_key
      if (j < 8) begin : g_low
         assign key_vec[j] = wwkc_pkg::fold(key_low_ff[BW*j +: BW]);
      end else if (j < 16) begin : g_high
         assign key_vec[j] = wwkc_pkg::fold(key_high_ff[BW*(j-8) +: BW]);
      end else begin : g_zero
         assign key_vec[j] = '0;
      end
   end

   assign accept     = req_bus.valid && req_bus.ready;
   assign text_fold  = wwkc_pkg::fold(req_bus.text_byte);
   assign text_space = wwkc_pkg::is_space(req_bus.text_byte);

   // cell i compares against keyword byte len-1-i
   for (genvar i = 0; i < Window; i++) begin : g_cell
      logic [LenW:0] key_idx;

      assign key_idx     = {1'b0, key_len} - (LenW+1)'(1) - (LenW+1)'(i);
      assign cell_cmp[i] = (i < MaxKeyLen) && ((LenW+1)'(i) < {1'b0, key_len});
      assign cell_key[i] = cell_cmp[i] ? key_vec[key_idx[KeyIW-1:0]] : '0;

      if (i == 0) begin : g_head
         assign chain_in[i] = text_fold;
      end else begin : g_link
         assign chain_in[i] = chain_out[i-1];
      end

      wwkc_cell u_cell (
         .clock    (clock),
         .shift_en (accept && !text_space),
         .byte_in  (chain_in[i]),
         .key_byte (cell_key[i]),
         .cmp_en   (cell_cmp[i]),
         .byte_out (chain_out[i]),
         .hit      (cell_hit[i]),
         .letter   (cell_letter[i])
      );
   end

   always_comb begin
      step.accept        = accept;
      step.space         = text_space;
      step.letter        = cell_letter[0];
      step.hit_all       = &cell_hit;
      step.letter_at_len = cell_letter[key_len];
      step.last          = req_bus.end_of_text;
   end

   wwkc_token_ctrl #(
      .MaxKeyLen (MaxKeyLen)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .key_len   (key_len),
      .count_out (count_out)
   );

   // output register: take a new request while the held count drains
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_bus.end_of_text) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.end_of_text) begin
         rsp_count_ff <= count_out;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.match_count = rsp_count_ff;

endmodule

FILE: hdl/wwkc_checker.sv
// ----------------------------------------------------------------------------
// wwkc_checker: port-level checks for the keyword counter
// Watches the request and response handshakes and the count timing.
// ----------------------------------------------------------------------------
module wwkc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_last,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [wwkc_pkg::COUNT_W-1:0] rsp_count
);

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
      else $error("stalled response dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> rsp_valid)
      else $error("no response after end of text");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last))
      else $error("response without end of text");

   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind whole_word_keyword_counter wwkc_checker u_wwkc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_last  (req_bus.end_of_text),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_count (rsp_bus.match_count)
);

FILE: verif/whole_word_keyword_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whole_word_keyword_counter_tb: self-checking bench for the keyword counter
// Streams texts through the request channel under random idle and stall,
// predicts every end-of-text count with a cycle-free software model of the
// token rules, and compares each response in order. Keywords of several
// lengths and byte flavors are loaded between phases while the block idles.
// ----------------------------------------------------------------------------
module whole_word_keyword_counter_tb;

   localparam int KeyMax     = wwkc_pkg::MAX_KEY_LEN_DEF;
   localparam int Window     = KeyMax + 1;
   localparam int CycleLimit = 400000;
   localparam int PhaseBytes = 120;
   localparam int PhaseCount = 12;
   localparam int LongHold   = 300;
   localparam int SettleWait = 4;

   typedef enum int {
      KW_LETTERS,
      KW_MIXED,
      KW_ALL_ONES,
      KW_ZERO,
      KW_SPACED
   } key_flavor_type;

   typedef struct {
      logic [wwkc_pkg::BYTE_W-1:0] text_byte;
      bit                          end_of_text;
   } text_req_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [wwkc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [wwkc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   wwkc_req_if req_bus ();
   wwkc_rsp_if rsp_bus ();

   whole_word_keyword_counter dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow registers and token state of the counter
   logic [63:0]                 key_lo;
   logic [63:0]                 key_hi;
   logic [4:0]                  key_len;
   logic [wwkc_pkg::BYTE_W-1:0] tok_window [Window];
   logic [4:0]                  tok_pos;
   bit                          tok_judged;
   bit                          tok_pending;
   logic [31:0]                 word_total;

   text_req_type                pending_text [$];
   logic [31:0]                 count_expect [$];
   logic [wwkc_pkg::BYTE_W-1:0] text_build [$];
   logic [wwkc_pkg::BYTE_W-1:0] kw [KeyMax];
   int                          kw_len = 1;

   text_req_type      next_req;
   logic [31:0]       want_count;
   int                fail_count  = 0;
   int                send_gap    = 0;
   int                recv_hold   = 0;
   int                hold_asked  = 0;
   int                hold_served = 0;
   int                texts_done  = 0;
   bit                no_idle     = 1'b0;
   bit                req_taken   = 1'b0;
   int unsigned       cycles      = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit is_ws(input logic [wwkc_pkg::BYTE_W-1:0] b);
      case (b)
         8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit is_alpha(input logic [wwkc_pkg::BYTE_W-1:0] b);
      logic [wwkc_pkg::BYTE_W-1:0] l;
      l = b | 8'h20;
      return (l >= 8'h61) && (l <= 8'h7A) && (b >= 8'h41);
   endfunction

   function automatic logic [wwkc_pkg::BYTE_W-1:0] to_lower(
         input logic [wwkc_pkg::BYTE_W-1:0] b);
      if (b >= 8'h41 && b <= 8'h5A) return b ^ 8'h20;
      return b;
   endfunction

   function automatic logic [wwkc_pkg::BYTE_W-1:0] key_char(input int i);
      if (i < 8) return to_lower(key_lo[8*i +: 8]);
      if (i < 16) return to_lower(key_hi[8*(i-8) +: 8]);
      return '0;
   endfunction

   function automatic void bump_total();
      if (word_total != 32'hFFFF_FFFF) word_total = word_total + 1;
   endfunction

   function automatic void drop_token();
      tok_pos     = '0;
      tok_judged  = 1'b0;
      tok_pending = 1'b0;
   endfunction

   function automatic void reset_counter_model();
      int i;
      key_lo  = '0;
      key_hi  = '0;
      key_len = 5'd1;
      for (i = 0; i < Window; i++) tok_window[i] = '0;
      drop_token();
      word_total = '0;
   endfunction

   // Advance the token state by one byte; returns 1 when a count is due.
   function automatic bit step_counter(input logic [wwkc_pkg::BYTE_W-1:0] b,
                                       input bit last,
                                       output logic [31:0] total);
      logic [wwkc_pkg::BYTE_W-1:0] c;
      int                          len;
      int                          i;
      bit                          hit;
      total = '0;
      len = (key_len > KeyMax) ? KeyMax : int'(key_len);
      if (is_ws(b)) begin
         if (tok_pending) bump_total();
         drop_token();
      end else begin
         c = to_lower(b);
         for (i = Window - 1; i > 0; i--) tok_window[i] = tok_window[i-1];
         tok_window[0] = c;
         if (tok_pos < Window) tok_pos = tok_pos + 1;
         if (tok_pending) begin
            // byte right after the occurrence settles the token
            tok_pending = 1'b0;
            tok_judged  = 1'b1;
            if (!is_alpha(c)) bump_total();
         end else if (!tok_judged && len > 0 && tok_pos >= len) begin
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
               if (tok_window[i] != key_char(len - 1 - i)) hit = 1'b0;
            end
            if (hit) begin
               if (tok_pos > len && is_alpha(tok_window[len])) tok_judged = 1'b1;
               else tok_pending = 1'b1;
            end
         end
      end
      if (last) begin
         if (tok_pending) bump_total();
         total = word_total;
         word_total = '0;
         drop_token();
      end
      return last;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH text %0d %s: got %0d expected %0d",
               $realtime, texts_done, what, got, want);
      fail_count++;
   endtask

   // ---------------------------------------------------------------- stimulus
   function automatic logic [wwkc_pkg::BYTE_W-1:0] solid_byte();
      logic [wwkc_pkg::BYTE_W-1:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_ws(b));
      return b;
   endfunction

   function automatic logic [wwkc_pkg::BYTE_W-1:0] letter_byte();
      return 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
   endfunction

   function automatic void add_filler(input int n);
      int i;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: text_build.push_back(letter_byte());
            1: text_build.push_back(8'($urandom_range(8'h30, 8'h39)));
            2: text_build.push_back($urandom_range(0, 1) ? 8'h2D : 8'h2E);
            default: text_build.push_back(solid_byte());
         endcase
      end
   endfunction

   // keyword bytes with the case of letters flipped at random
   function automatic void add_keyword(input int n);
      int i;
      for (i = 0; i < n; i++) begin
         if (is_alpha(kw[i]) && $urandom_range(0, 1)) text_build.push_back(kw[i] ^ 8'h20);
         else text_build.push_back(kw[i]);
      end
   endfunction

   function automatic void add_separator();
      int n;
      int i;
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 7))
            0: text_build.push_back(8'h09);
            1: text_build.push_back(8'h0A);
            2: text_build.push_back(8'h0B);
            3: text_build.push_back(8'h0C);
            4: text_build.push_back(8'h0D);
            default: text_build.push_back(8'h20);
         endcase
      end
   endfunction

   function automatic void add_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) text_build.push_back(s[i]);
   endfunction

   function automatic void make_text();
      int tokens;
      int t;
      int i;
      tokens = $urandom_range(1, 6);
      for (t = 0; t < tokens; t++) begin
         if (t != 0) add_separator();
         case ($urandom_range(0, 9))
            0, 1: add_keyword(kw_len);
            2, 3: begin
               add_filler($urandom_range(0, 2));
               add_keyword(kw_len);
               add_filler($urandom_range(0, 2));
            end
            4: add_filler($urandom_range(1, 8));
            5: begin
               // long token, occurrence may lie past the window
               add_filler($urandom_range(10, 25));
               add_keyword(kw_len);
               add_filler($urandom_range(0, 5));
            end
            6: begin
               // a letter-bound first occurrence hides a clean second one
               text_build.push_back(letter_byte());
               add_keyword(kw_len);
               text_build.push_back(8'h2D);
               add_keyword(kw_len);
            end
            7: begin
               add_keyword(kw_len - 1);
               add_filler($urandom_range(1, 2));
            end
            8: begin
               for (i = 0; i < $urandom_range(1, 6); i++)
                  text_build.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               add_keyword(kw_len);
               add_filler(1);
            end
         endcase
      end
      if ($urandom_range(0, 3) == 0) add_separator();
      if (text_build.size() == 0) text_build.push_back(solid_byte());
   endfunction

   // hand the built text to the driver, last byte marked
   function automatic int send_text();
      int n;
      int i;
      n = text_build.size();
      for (i = 0; i < n; i++)
         pending_text.push_back('{text_byte: text_build[i], end_of_text: (i == n - 1)});
      text_build.delete();
      return n;
   endfunction

   task automatic write_reg(input wwkc_pkg::csr_index_type idx,
                            input logic [wwkc_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         wwkc_pkg::CSR_KEY_CHARS_LOW:  key_lo  = data;
         wwkc_pkg::CSR_KEY_CHARS_HIGH: key_hi  = data;
         wwkc_pkg::CSR_KEY_LENGTH:     key_len = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_keyword(input int len, input key_flavor_type flavor);
      logic [63:0]                 lo;
      logic [63:0]                 hi;
      logic [wwkc_pkg::BYTE_W-1:0] b;
      int                          i;
      for (i = 0; i < KeyMax; i++) begin
         case (flavor)
            KW_ALL_ONES: b = 8'hFF;
            KW_ZERO:     b = 8'h00;
            KW_MIXED:    b = $urandom_range(0, 1) ? solid_byte() : letter_byte();
            KW_SPACED:   b = (i == len / 2) ? 8'h20 : letter_byte();
            default:     b = letter_byte();
         endcase
         // bytes past the length are junk the block must ignore
         if (i >= len && flavor != KW_ALL_ONES && flavor != KW_ZERO)
            b = 8'($urandom_range(0, 255));
         kw[i] = b;
         if (i < 8) lo[8*i +: 8] = b;
         else hi[8*(i-8) +: 8] = b;
      end
      kw_len = len;
      write_reg(wwkc_pkg::CSR_KEY_CHARS_LOW, lo);
      write_reg(wwkc_pkg::CSR_KEY_CHARS_HIGH, hi);
      write_reg(wwkc_pkg::CSR_KEY_LENGTH, 64'(len));
   endtask

   task automatic wait_drained();
      while (pending_text.size() != 0 || count_expect.size() != 0 || req_bus.valid === 1'b1)
         @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------ driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.text_byte   <= '0;
         req_bus.end_of_text <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (send_gap != 0) begin
            req_bus.valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_text.size() != 0) begin
            next_req = pending_text.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.text_byte   <= next_req.text_byte;
            req_bus.end_of_text <= next_req.end_of_text;
            send_gap <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (recv_hold != 0) begin
         rsp_bus.ready <= 1'b0;
         recv_hold <= recv_hold - 1;
      end else if (hold_served != hold_asked) begin
         rsp_bus.ready <= 1'b0;
         recv_hold <= LongHold;
         hold_served <= hold_asked;
      end else if (no_idle) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) < 70);
         if ($urandom_range(0, 99) < 2) recv_hold <= $urandom_range(15, 50);
      end
   end

   // ----------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (reset) begin
         reset_counter_model();
         req_taken <= 1'b0;
      end else begin
         // check the response first so a count due at this edge is not matched
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (count_expect.size() == 0) begin
               report_mismatch("count with no text pending", rsp_bus.match_count, '0);
            end else begin
               want_count = count_expect.pop_front();
               if (rsp_bus.match_count !== want_count)
                  report_mismatch("match_count", rsp_bus.match_count, want_count);
            end
            texts_done++;
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            if (step_counter(req_bus.text_byte, req_bus.end_of_text, want_count))
               count_expect.push_back(want_count);
         end
         req_taken <= (req_bus.valid === 1'b1) && (req_bus.ready === 1'b1);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("whole_word_keyword_counter regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int phase;
      int queued;
      reset     = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // keyword "Cat": folding, exact match, clean edges, letter after,
      // first occurrence only, zero and high bytes around an occurrence
      write_reg(wwkc_pkg::CSR_KEY_CHARS_LOW, 64'h0000_0000_0074_6143);
      write_reg(wwkc_pkg::CSR_KEY_CHARS_HIGH, 64'h0);
      write_reg(wwkc_pkg::CSR_KEY_LENGTH, 64'd3);
      add_string("CaT 9cat. cats");
      void'(send_text());
      add_string("xcat-cat");
      void'(send_text());
      text_build.push_back(8'h00);
      add_string("cat");
      text_build.push_back(8'h80);
      void'(send_text());
      wait_drained();

      for (phase = 1; phase <= PhaseCount; phase++) begin
         case (phase)
            1:  load_keyword(1, KW_LETTERS);
            2:  load_keyword(KeyMax, KW_LETTERS);
            3:  load_keyword(KeyMax, KW_ALL_ONES);
            4:  load_keyword(KeyMax, KW_ZERO);
            5:  load_keyword($urandom_range(1, KeyMax), KW_MIXED);
            6:  load_keyword(4, KW_SPACED);
            8:  load_keyword(2, KW_LETTERS);
            9:  load_keyword(1, KW_MIXED);
            default: load_keyword($urandom_range(1, KeyMax), KW_LETTERS);
         endcase
         no_idle = (phase == 7);
         // receiver holds off at the start of this phase, so a held count stalls requests
         if (phase == 5) hold_asked++;
         queued = 0;
         while (queued < PhaseBytes) begin
            make_text();
            queued += send_text();
            // sender waits for every count before the next text
            if (phase % 4 == 3) wait_drained();
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("whole_word_keyword_counter regression: pass");
      end else begin
         $display("whole_word_keyword_counter regression: fail");
      end
      $finish;
   end

endmodule
